### design/read_pileup_allele_counter_defines.svh
// Assertion macros for the read pileup allele counter.
// Depends on nothing; taken in by the top level with an include.
`ifndef READ_PILEUP_ALLELE_COUNTER_DEFINES_SVH
`define READ_PILEUP_ALLELE_COUNTER_DEFINES_SVH

// The consequent must hold in the same cycle as the condition.
`define RPAC_ASSERT_NOW(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("rpac assertion failed");

// The consequent must hold in the cycle after the condition.
`define RPAC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("rpac assertion failed");

`endif

### design/rpac_pkg.sv
// Shared types, constants and lookup functions of the read pileup allele counter.
// Depends on nothing; used by every module of the block.
package rpac_pkg;

	localparam int COUNT_BITS_DEFAULT = 32;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 31;

	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW = $clog2(CQ_DEPTH);
	localparam int OQ_DEPTH = 2;
	localparam int OQ_AW = $clog2(OQ_DEPTH);

	localparam logic [15:0] SKIP_MASK = 16'h0F04;

	typedef enum logic [1:0] {
		CMD_HEADER = 2'd0,
		CMD_OP     = 2'd1,
		CMD_BASE   = 2'd2,
		CMD_FINISH = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_POS  = 3'd0,
		REG_REF_BASE    = 3'd1,
		REG_ALT_BASE    = 3'd2,
		REG_MAPQ_LIMIT  = 3'd3,
		REG_BASEQ_LIMIT = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		WALK_SEARCHING = 3'b001,
		WALK_HIT       = 3'b010,
		WALK_MISS      = 3'b100
	} walk_status_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [15:0]        read_flags;
		logic [7:0]         mapping_quality;
		logic signed [31:0] read_start;
		logic [3:0]         op_code;
		logic [27:0]        op_length;
		logic [7:0]         base_quality;
		logic [3:0]         base_code;
	} item_t;

	typedef struct packed {
		logic [31:0] ref_count;
		logic [31:0] alt_count;
	} result_t;

	typedef struct packed {
		logic [30:0] target_pos;
		logic [7:0]  ref_base;
		logic [7:0]  alt_base;
		logic [7:0]  mapq_limit;
		logic [7:0]  baseq_limit;
	} cfg_t;

	typedef struct packed {
		cmd_t               command;
		logic               passes;
		logic signed [31:0] start;
		logic               cons_query;
		logic               cons_ref;
		logic [27:0]        op_length;
		logic               qual_ok;
		logic               is_ref;
		logic               is_alt;
	} work_t;

	function automatic logic [7:0] nt_letter(input logic [3:0] code);
		logic [7:0] c;
		case (code)
			4'd0:    c = 8'h3D;
			4'd1:    c = 8'h41;
			4'd2:    c = 8'h43;
			4'd3:    c = 8'h4D;
			4'd4:    c = 8'h47;
			4'd5:    c = 8'h52;
			4'd6:    c = 8'h53;
			4'd7:    c = 8'h56;
			4'd8:    c = 8'h54;
			4'd9:    c = 8'h57;
			4'd10:   c = 8'h59;
			4'd11:   c = 8'h48;
			4'd12:   c = 8'h4B;
			4'd13:   c = 8'h44;
			4'd14:   c = 8'h42;
			default: c = 8'h4E;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
	endfunction

	// Bit 0 set when the op consumes query bases, bit 1 when it consumes reference.
	function automatic logic [1:0] op_kind(input logic [3:0] code);
		logic [1:0] k;
		case (code)
			4'd0, 4'd7, 4'd8: k = 2'b11;
			4'd1, 4'd4:       k = 2'b01;
			4'd2, 4'd3:       k = 2'b10;
			default:          k = 2'b00;
		endcase
		return k;
	endfunction

endpackage

### design/rpac_front.sv
// Front end: takes input beats, classifies them against the configuration
// and holds them in a short command queue. Depends on rpac_pkg.
module rpac_front (
	input  logic           clk,
	input  logic           arst_n,
	input  rpac_pkg::cfg_t cfg,
	input  rpac_pkg::item_t item,
	input  logic           push,
	output logic           full,
	output rpac_pkg::work_t work,
	output logic           work_valid,
	input  logic           work_take
);
	import rpac_pkg::*;

	localparam logic [CQ_AW:0] FULL_COUNT = (CQ_AW + 1)'(CQ_DEPTH);

	work_t            queue_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_AW:0]   count_q;
	work_t            entry;
	logic [1:0]       kind;
	logic [7:0]       letter;
	logic             wr_en;
	logic             rd_en;

	always_comb begin
		kind = op_kind(item.op_code);
		letter = nt_letter(item.base_code);
		entry.command = cmd_t'(item.command);
		entry.passes = ((item.read_flags & SKIP_MASK) == 16'h0000)
			&& (item.mapping_quality >= cfg.mapq_limit);
		entry.start = item.read_start;
		entry.cons_query = kind[0];
		entry.cons_ref = kind[1];
		entry.op_length = item.op_length;
		entry.qual_ok = item.base_quality >= cfg.baseq_limit;
		entry.is_ref = letter == upcase(cfg.ref_base);
		entry.is_alt = letter == upcase(cfg.alt_base);
	end

	assign full = count_q == FULL_COUNT;
	assign work_valid = count_q != '0;
	assign work = queue_q[rd_ptr_q];
	assign wr_en = push && !full;
	assign rd_en = work_take && work_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/rpac_back.sv
// Back end: walks the CIGAR ops to the site, checks each base against the hit
// offset and keeps the saturating allele tallies. Depends on rpac_pkg.
module rpac_back #(
	parameter int COUNT_BITS = rpac_pkg::COUNT_BITS_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [30:0]      target_pos,
	input  rpac_pkg::work_t  work,
	input  logic             work_valid,
	output logic             work_take,
	input  logic             res_full,
	output logic             res_push,
	output rpac_pkg::result_t res
);
	import rpac_pkg::*;

	logic signed [32:0]    walk_ref_pos_q;
	logic [31:0]           walk_query_pos_q;
	logic [31:0]           hit_query_pos_q;
	walk_status_t          walk_status_q;
	logic                  read_passes_q;
	logic [31:0]           base_index_q;
	logic [COUNT_BITS-1:0] ref_tally_q;
	logic [COUNT_BITS-1:0] alt_tally_q;

	logic signed [32:0] tgt;
	logic signed [32:0] op_end;
	logic signed [32:0] diff;
	logic signed [32:0] next_ref_pos;
	logic [32:0]        hit_sum;
	logic [32:0]        step_sum;
	logic               in_range;
	logic               base_counts;

	assign work_take = work_valid && !(work.command == CMD_FINISH && res_full);
	assign res_push = work_take && work.command == CMD_FINISH;
	assign res.ref_count = 32'(ref_tally_q);
	assign res.alt_count = 32'(alt_tally_q);

	always_comb begin
		tgt = $signed({2'b00, target_pos});
		op_end = walk_ref_pos_q + $signed({5'b00000, work.op_length});
		diff = tgt - walk_ref_pos_q;
		hit_sum = {1'b0, walk_query_pos_q} + {5'b00000, diff[27:0]};
		step_sum = {1'b0, walk_query_pos_q} + {5'b00000, work.op_length};
		in_range = work.cons_ref && (tgt >= walk_ref_pos_q) && (tgt < op_end);
		next_ref_pos = work.cons_ref ? op_end : walk_ref_pos_q;
		base_counts = read_passes_q && walk_status_q == WALK_HIT
			&& base_index_q == hit_query_pos_q && work.qual_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_ref_pos_q <= '0;
			walk_query_pos_q <= '0;
			hit_query_pos_q <= '0;
			walk_status_q <= WALK_SEARCHING;
			read_passes_q <= 1'b0;
			base_index_q <= '0;
			ref_tally_q <= '0;
			alt_tally_q <= '0;
		end else if (work_take) begin
			unique case (work.command)
				CMD_HEADER: begin
					read_passes_q <= work.passes;
					walk_ref_pos_q <= {work.start[31], work.start};
					walk_query_pos_q <= '0;
					hit_query_pos_q <= '0;
					walk_status_q <= WALK_SEARCHING;
					base_index_q <= '0;
				end
				CMD_OP: begin
					if (walk_status_q == WALK_SEARCHING) begin
						if (in_range) begin
							if (work.cons_query) begin
								hit_query_pos_q <= hit_sum[32] ? '1 : hit_sum[31:0];
								walk_status_q <= WALK_HIT;
							end else begin
								walk_status_q <= WALK_MISS;
							end
						end else begin
							walk_ref_pos_q <= next_ref_pos;
							if (work.cons_query) begin
								walk_query_pos_q <= step_sum[32] ? '1 : step_sum[31:0];
							end
							if (next_ref_pos > tgt) begin
								walk_status_q <= WALK_MISS;
							end
						end
					end
				end
				CMD_BASE: begin
					if (base_counts) begin
						if (work.is_ref) begin
							if (ref_tally_q != '1) begin
								ref_tally_q <= ref_tally_q + 1'b1;
							end
						end else if (work.is_alt) begin
							if (alt_tally_q != '1) begin
								alt_tally_q <= alt_tally_q + 1'b1;
							end
						end
					end
					if (base_index_q != '1) begin
						base_index_q <= base_index_q + 1'b1;
					end
				end
				CMD_FINISH: begin
					ref_tally_q <= '0;
					alt_tally_q <= '0;
				end
				default: begin
					walk_status_q <= walk_status_q;
				end
			endcase
		end
	end

endmodule

### design/rpac_res_queue.sv
// Result queue: holds finished tallies until the consumer pops them.
// Depends on rpac_pkg.
module rpac_res_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  rpac_pkg::result_t res_in,
	input  logic              res_push,
	output logic              res_full,
	output rpac_pkg::result_t result,
	output logic              empty,
	input  logic              pop
);
	import rpac_pkg::*;

	localparam logic [OQ_AW:0] FULL_COUNT = (OQ_AW + 1)'(OQ_DEPTH);

	result_t          queue_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_AW:0]   count_q;
	logic             wr_en;
	logic             rd_en;

	assign res_full = count_q == FULL_COUNT;
	assign empty = count_q == '0;
	assign result = queue_q[rd_ptr_q];
	assign wr_en = res_push && !res_full;
	assign rd_en = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/read_pileup_allele_counter.sv
// Top level of the read pileup allele counter: configuration registers,
// front end, back end and result queue. Depends on rpac_pkg and the defines header.
//
// Channel   Handshake              Payload
// config    cfg_write              cfg_index, cfg_data
// input     push, full             item (rpac_pkg::item_t)
// result    empty, pop             result (rpac_pkg::result_t)
//
// One input beat per cycle is sustained while the back end does not stall; the back end
// retires one queued item each cycle when not stalled. An item goes through the command
// queue to the back end; a finish beat's tallies enter the result queue as it is retired.
// The back end stalls only on a finish beat while the two-entry result queue is full.
// Reset is asynchronous and clears queues, read state and tallies; no clearing pass.
`include "read_pileup_allele_counter_defines.svh"

module read_pileup_allele_counter #(
	parameter int COUNT_BITS = rpac_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [rpac_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rpac_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                push,
	output logic                                full,
	input  rpac_pkg::item_t                     item,
	output logic                                empty,
	input  logic                                pop,
	output rpac_pkg::result_t                   result
);
	import rpac_pkg::*;

	cfg_t    cfg_q;
	work_t   work;
	logic    work_valid;
	logic    work_take;
	logic    res_full;
	logic    res_push;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_pos <= '0;
			cfg_q.ref_base <= 8'd65;
			cfg_q.alt_base <= 8'd67;
			cfg_q.mapq_limit <= '0;
			cfg_q.baseq_limit <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_TARGET_POS:  cfg_q.target_pos <= cfg_data[30:0];
				REG_REF_BASE:    cfg_q.ref_base <= cfg_data[7:0];
				REG_ALT_BASE:    cfg_q.alt_base <= cfg_data[7:0];
				REG_MAPQ_LIMIT:  cfg_q.mapq_limit <= cfg_data[7:0];
				REG_BASEQ_LIMIT: cfg_q.baseq_limit <= cfg_data[7:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	rpac_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (item),
		.push       (push),
		.full       (full),
		.work       (work),
		.work_valid (work_valid),
		.work_take  (work_take)
	);

	rpac_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.target_pos (cfg_q.target_pos),
		.work       (work),
		.work_valid (work_valid),
		.work_take  (work_take),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res)
	);

	rpac_res_queue u_res_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_in   (res),
		.res_push (res_push),
		.res_full (res_full),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

	`RPAC_ASSERT_NOW(a_no_result_overflow, clk, arst_n, res_push, !res_full)
	`RPAC_ASSERT_NOW(a_stall_only_on_full, clk, arst_n, work_valid && !work_take, res_full)
	`RPAC_ASSERT_NEXT(a_finish_shows, clk, arst_n, res_push, !empty)

endmodule

### tb/read_pileup_allele_counter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for read_pileup_allele_counter: queued reads, CIGAR ops and
// bases against a cycle-free allele tally predictor, with random gaps and stalls.
// Depends on rpac_pkg and the read_pileup_allele_counter RTL.
module read_pileup_allele_counter_tb;
	import rpac_pkg::*;

	localparam logic [3:0] OP_MATCH = 4'd0;
	localparam logic [3:0] OP_INS   = 4'd1;
	localparam logic [3:0] OP_DEL   = 4'd2;
	localparam logic [3:0] OP_SKIP  = 4'd3;
	localparam logic [3:0] OP_SOFT  = 4'd4;
	localparam logic [3:0] OP_EQUAL = 4'd7;
	localparam logic [3:0] OP_DIFF  = 4'd8;

	localparam logic [127:0] NT_LETTERS = "=ACMGRSVTWYHKDBN";
	localparam longint WORD_MAX = 64'hFFFF_FFFF;
	localparam int LONG_HOLD_CYCLES = 300;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_TARGET_POS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	item_t item = '0;
	logic empty;
	logic pop = 1'b0;
	result_t result;

	read_pileup_allele_counter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	// Predictor copy of the settings and of the per-read walk state.
	logic [30:0] site_pos = '0;
	logic [7:0] ref_letter = 8'd65;
	logic [7:0] alt_letter = 8'd67;
	logic [7:0] mapq_floor = '0;
	logic [7:0] baseq_floor = '0;
	logic signed [32:0] walk_ref = '0;
	logic [31:0] walk_query = '0;
	logic [31:0] hit_offset = '0;
	walk_status_t walk_state = WALK_SEARCHING;
	logic read_ok = 1'b0;
	logic [31:0] base_idx = '0;
	logic [31:0] ref_hits = '0;
	logic [31:0] alt_hits = '0;

	item_t beats_to_send[$];
	result_t counts_due[$];
	result_t due_now;

	int errors = 0;
	int beats_in = 0;
	int results_out = 0;
	int settings_done = 0;
	int gen_beats = 0;
	int gen_finishes = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_pct = 0;
	int mode_left = 0;
	int burst_left = 0;
	int gap_left = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [1:0] query_ref_use(input logic [3:0] code);
		case (code)
			OP_MATCH, OP_EQUAL, OP_DIFF: return 2'b11;
			OP_INS, OP_SOFT:             return 2'b01;
			OP_DEL, OP_SKIP:             return 2'b10;
			default:                     return 2'b00;
		endcase
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] a, input longint b);
		longint s;
		s = longint'(a) + b;
		return (s > WORD_MAX) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? (c & 8'hDF) : c;
	endfunction

	task automatic predict_pileup(input item_t b);
		longint site;
		longint here;
		longint stop;
		logic [1:0] use_bits;
		logic [7:0] letter;
		case (b.command)
			CMD_HEADER: begin
				read_ok = ((b.read_flags & SKIP_MASK) == '0) && (b.mapping_quality >= mapq_floor);
				walk_ref = {b.read_start[31], b.read_start};
				walk_query = '0;
				hit_offset = '0;
				walk_state = WALK_SEARCHING;
				base_idx = '0;
			end
			CMD_OP: begin
				use_bits = query_ref_use(b.op_code);
				site = longint'(site_pos);
				here = longint'(walk_ref);
				stop = here + longint'(b.op_length);
				if (walk_state == WALK_SEARCHING) begin
					if (use_bits[1] && site >= here && site < stop) begin
						if (use_bits[0]) begin
							hit_offset = sat_add(walk_query, site - here);
							walk_state = WALK_HIT;
						end else begin
							walk_state = WALK_MISS;
						end
					end else begin
						if (use_bits[1]) begin
							here = stop;
							walk_ref = stop[32:0];
						end
						if (use_bits[0]) walk_query = sat_add(walk_query, longint'(b.op_length));
						if (here > site) walk_state = WALK_MISS;
					end
				end
			end
			CMD_BASE: begin
				if (read_ok && walk_state == WALK_HIT && base_idx == hit_offset
						&& b.base_quality >= baseq_floor) begin
					letter = NT_LETTERS[8*(15 - b.base_code) +: 8];
					if (letter == fold_case(ref_letter)) begin
						if (ref_hits != 32'hFFFF_FFFF) ref_hits++;
					end else if (letter == fold_case(alt_letter)) begin
						if (alt_hits != 32'hFFFF_FFFF) alt_hits++;
					end
				end
				if (base_idx != 32'hFFFF_FFFF) base_idx++;
			end
			CMD_FINISH: begin
				due_now.ref_count = ref_hits;
				due_now.alt_count = alt_hits;
				counts_due.push_back(due_now);
				ref_hits = '0;
				alt_hits = '0;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (push && !full) begin
				predict_pileup(item);
				beats_in++;
			end
			if (push && full) begin
				// The beat on offer stays until the block takes it.
			end else if (gap_left > 0) begin
				gap_left--;
				push <= 1'b0;
			end else if (beats_to_send.size() != 0) begin
				item <= beats_to_send.pop_front();
				push <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			hold_left = 0;
			mode_left = 0;
			stall_pct = 0;
		end else begin
			if (pop && !empty) begin
				results_out++;
				if (counts_due.size() == 0) begin
					errors++;
					$display("%0t: count beat with nothing expected: ref_count %0d alt_count %0d",
						$time, result.ref_count, result.alt_count);
				end else begin
					due_now = counts_due.pop_front();
					if (result.ref_count !== due_now.ref_count) begin
						errors++;
						$display("%0t: ref_count expected %0d actual %0d",
							$time, due_now.ref_count, result.ref_count);
					end
					if (result.alt_count !== due_now.alt_count) begin
						errors++;
						$display("%0t: alt_count expected %0d actual %0d",
							$time, due_now.alt_count, result.alt_count);
					end
				end
			end
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(16, 96);
					case ($urandom_range(0, 2))
						0: stall_pct = 0;
						1: stall_pct = 30;
						default: stall_pct = 75;
					endcase
				end else begin
					mode_left--;
				end
				pop <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	task automatic queue_beat(input item_t b);
		beats_to_send.push_back(b);
		gen_beats++;
		if (b.command == CMD_FINISH) gen_finishes++;
	endtask

	function automatic item_t noise_beat();
		logic [127:0] r;
		r = {$urandom, $urandom, $urandom, $urandom};
		return r[$bits(item_t)-1:0];
	endfunction

	task automatic add_header(input logic [15:0] flags, input logic [7:0] mq,
			input logic signed [31:0] st);
		item_t b;
		b = noise_beat();
		b.command = CMD_HEADER;
		b.read_flags = flags;
		b.mapping_quality = mq;
		b.read_start = st;
		queue_beat(b);
	endtask

	task automatic add_op(input logic [3:0] code, input logic [27:0] len);
		item_t b;
		b = noise_beat();
		b.command = CMD_OP;
		b.op_code = code;
		b.op_length = len;
		queue_beat(b);
	endtask

	task automatic add_base(input logic [7:0] q, input logic [3:0] code);
		item_t b;
		b = noise_beat();
		b.command = CMD_BASE;
		b.base_quality = q;
		b.base_code = code;
		queue_beat(b);
	endtask

	task automatic add_finish();
		item_t b;
		b = noise_beat();
		b.command = CMD_FINISH;
		queue_beat(b);
	endtask

	function automatic logic [3:0] random_op_code();
		return ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
	endfunction

	function automatic logic [27:0] random_op_len();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return '0;
		if (r == 1) return 28'($urandom);
		return 28'($urandom_range(1, 8));
	endfunction

	function automatic logic [7:0] random_quality();
		return ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom);
	endfunction

	function automatic logic [3:0] random_base_code();
		return ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'(1 << $urandom_range(0, 3));
	endfunction

	function automatic logic [7:0] pick_allele();
		logic [3:0] code;
		logic [7:0] c;
		code = random_base_code();
		c = NT_LETTERS[8*(15 - code) +: 8];
		if (c != 8'h3D && $urandom_range(0, 1) == 1) c = c | 8'h20;
		return c;
	endfunction

	task automatic add_random_read();
		logic [15:0] flags;
		logic signed [31:0] st;
		logic [3:0] code;
		logic [27:0] len;
		logic [1:0] use_bits;
		int r;
		int qlen;
		flags = 16'($urandom);
		if ($urandom_range(0, 2) != 0) flags = flags & ~SKIP_MASK;
		r = $urandom_range(0, 19);
		if (r < 15) st = 32'(longint'(site_pos) - longint'($urandom_range(0, 20)));
		else if (r < 17) st = 32'(longint'(site_pos) + longint'($urandom_range(1, 5)));
		else st = 32'($urandom);
		add_header(flags, ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom), st);
		if ($urandom_range(0, 24) == 0) begin
			// Insertions long enough to pin the query offset at its ceiling.
			repeat (17) add_op(OP_INS, 28'hFFF_FFFF);
			add_op(OP_MATCH, 28'($urandom_range(1, 40)));
			repeat ($urandom_range(0, 4)) add_base(random_quality(), random_base_code());
		end else begin
			qlen = 0;
			repeat ($urandom_range(1, 5)) begin
				code = random_op_code();
				len = random_op_len();
				use_bits = query_ref_use(code);
				if (use_bits[0]) qlen = (len > 28'd24) ? 25 : qlen + int'(len);
				add_op(code, len);
			end
			repeat ((qlen > 24) ? 24 : qlen) add_base(random_quality(), random_base_code());
		end
	endtask

	task automatic put_reg(input reg_idx_t idx, input logic [30:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
	endtask

	task automatic write_settings(input logic [30:0] site, input logic [7:0] rb,
			input logic [7:0] ab, input logic [7:0] mq, input logic [7:0] bq);
		put_reg(REG_TARGET_POS, site);
		put_reg(REG_REF_BASE, {23'($urandom), rb});
		put_reg(REG_ALT_BASE, {23'($urandom), ab});
		put_reg(REG_MAPQ_LIMIT, {23'($urandom), mq});
		put_reg(REG_BASEQ_LIMIT, {23'($urandom), bq});
		@(posedge clk);
		cfg_write <= 1'b0;
		site_pos = site;
		ref_letter = rb;
		alt_letter = ab;
		mapq_floor = mq;
		baseq_floor = bq;
		settings_done++;
	endtask

	task automatic drain();
		do @(negedge clk);
		while (beats_to_send.size() != 0 || push || counts_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int p;
		int r;
		int first_beat;
		int first_finish;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		write_settings(31'd100, "t", "G", 8'd20, 8'd30);
		@(negedge clk);
		// Ops and bases before any header act on the reset read state, which never counts.
		add_base(8'd255, 4'd8);
		add_op(OP_MATCH, 28'd200);
		add_finish();
		add_header(16'h0000, 8'd20, 32'sd98);
		add_op(OP_SOFT, 28'd2);
		add_op(OP_MATCH, 28'd5);
		add_op(OP_DEL, 28'd1);
		repeat (4) add_base(8'd255, 4'd1);
		add_base(8'd30, 4'd8);
		add_header(16'hFFFF, 8'd255, -32'sd1);
		add_op(OP_MATCH, 28'hFFF_FFFF);
		add_base(8'd255, 4'd8);
		add_header(16'hF0FB, 8'd255, 32'sh7FFF_FFFF);
		add_op(OP_INS, 28'd3);
		add_header(16'h0010, 8'd20, 32'sd99);
		add_op(OP_DEL, 28'd3);
		add_header(16'h0000, 8'd255, 32'sd100);
		add_op(OP_EQUAL, 28'd1);
		add_base(8'd29, 4'd8);
		add_header(16'h0000, 8'd255, 32'sd100);
		add_op(OP_DIFF, 28'd1);
		add_base(8'd0, 4'd4);
		add_finish();
		drain();

		for (p = 0; p < 6; p++) begin
			case (p)
				0: write_settings(31'd0, pick_allele(), pick_allele(), 8'd0, 8'd0);
				1: write_settings(31'h7FFF_FFFF, pick_allele(), pick_allele(), 8'd255, 8'd255);
				2: write_settings(31'($urandom_range(0, 100000)), 8'd0, 8'd255,
					8'($urandom_range(0, 60)), 8'($urandom_range(0, 40)));
				default: write_settings(31'($urandom_range(0, 100000)), pick_allele(),
					pick_allele(), 8'($urandom_range(0, 60)), 8'($urandom_range(0, 40)));
			endcase
			@(negedge clk);
			first_beat = gen_beats;
			first_finish = gen_finishes;
			while (gen_beats - first_beat < 115 || gen_finishes - first_finish < 7) begin
				r = $urandom_range(0, 99);
				if (r < 72) begin
					add_random_read();
					if ($urandom_range(0, 9) < 5) add_finish();
				end else if (r < 80) begin
					add_finish();
				end else if (r < 88) begin
					repeat ($urandom_range(1, 4)) queue_beat(noise_beat());
				end else begin
					repeat ($urandom_range(1, 3)) add_op(random_op_code(), random_op_len());
					repeat ($urandom_range(0, 3)) add_base(random_quality(), random_base_code());
				end
			end
			if (p == 2 || p == 4) hold_asks++;
			drain();
		end

		$display("Drove %0d beats under %0d register settings and compared %0d count beats,",
			beats_in, settings_done, results_out);
		$display("with %0d long receiver hold-offs that backed the block up to its input.",
			hold_asks);
		if (errors == 0) begin
			$display("read_pileup_allele_counter_tb: clean");
		end else begin
			$display("read_pileup_allele_counter_tb: errors");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("read_pileup_allele_counter_tb: errors");
		$finish;
	end

endmodule
